// ===== sv/gev_pkg.sv =====
// Shared types and constants for the gamepad event to HID report block.
package gev_pkg;

  localparam int unsigned NumButtons = 17;
  localparam int unsigned NumAxes    = 6;
  localparam int unsigned ReportBtns = 13;

  // Button slots in the button state vector.
  localparam logic [4:0] IdxL1     = 5'd4;
  localparam logic [4:0] IdxR1     = 5'd5;
  localparam logic [4:0] IdxSelect = 5'd8;
  localparam logic [4:0] IdxStart  = 5'd9;
  localparam logic [4:0] IdxUp     = 5'd13;
  localparam logic [4:0] IdxDown   = 5'd14;
  localparam logic [4:0] IdxLeft   = 5'd15;
  localparam logic [4:0] IdxRight  = 5'd16;

  // Axis slots (evdev absolute codes).
  localparam logic [2:0] AxLeftX   = 3'd0;
  localparam logic [2:0] AxLeftY   = 3'd1;
  localparam logic [2:0] AxLeftTrg = 3'd2;
  localparam logic [2:0] AxRightX  = 3'd3;
  localparam logic [2:0] AxRightY  = 3'd4;
  localparam logic [2:0] AxRightTrg = 3'd5;

  typedef enum logic [1:0] {
    KIND_BUTTON = 2'd0,
    KIND_AXIS   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Hat encodings.
  localparam logic [3:0] HatUp        = 4'd0;
  localparam logic [3:0] HatUpRight   = 4'd1;
  localparam logic [3:0] HatRight     = 4'd2;
  localparam logic [3:0] HatDownRight = 4'd3;
  localparam logic [3:0] HatDown      = 4'd4;
  localparam logic [3:0] HatDownLeft  = 4'd5;
  localparam logic [3:0] HatLeft      = 4'd6;
  localparam logic [3:0] HatUpLeft    = 4'd7;
  localparam logic [3:0] HatNeutral   = 4'd8;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         code;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [12:0] button_bits;
    logic [3:0]  hat;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_trigger;
    logic [7:0]  right_trigger;
    logic        usb_mode;
    logic        pairing_mode;
    logic        discoverable;
  } out_item_t;

  // Complete controller state, passed from the state unit to the formatter.
  typedef struct packed {
    logic [NumButtons-1:0]           buttons;
    logic [NumAxes-1:0][15:0]        axes;
    logic                            usb;
    logic                            pairing;
    logic                            discoverable;
  } pad_state_t;

endpackage

// ===== sv/gamepad_event_to_hid_report.sv =====
// Top level: evdev event stream in, HID gamepad report stream out.
//
// Usage:
//   in_valid/in_ready/in_data carry one evdev event per transaction: a button
//   change, an absolute axis change, a clear of buttons and axes, or a no-op.
//   out_valid/out_ready/out_data carry one HID report per input transaction,
//   built from the controller state after that event was applied.
// Output register: a report is valid the cycle after its event is accepted.
// Throughput: one event per cycle unless the output stalls. The state update and report packing are
//   a single code compare and a field pack ahead of the report register.
// Stall: the report register holds while out_ready is low; in_ready drops
//   only when that register is full and not being drained, so an event is
//   taken in the same cycle the waiting report leaves.
// Reset (rst_n low, synchronous): buttons and axes zero, USB and pairing
//   flags clear, discoverable set; no report pending.
// Mode combos (checked after every button event): SELECT+START toggles USB
//   mode, SELECT+L1 sets pairing and discoverable, SELECT+R1 toggles
//   discoverable, in that order.
module gamepad_event_to_hid_report (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gev_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gev_pkg::out_item_t out_data
);

  logic                accept;
  gev_pkg::pad_state_t state_nxt;
  gev_pkg::out_item_t  report;
  logic                out_valid_r;
  gev_pkg::out_item_t  out_data_r;

  // Report slot is free when empty or draining this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  gev_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .state_nxt (state_nxt)
  );

  gev_report u_report (
    .state  (state_nxt),
    .report (report)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= report;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/gev_state.sv =====
// Controller state registers and per-event update logic.
module gev_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  gev_pkg::in_item_t   item,
  output gev_pkg::pad_state_t state_nxt
);

  gev_pkg::pad_state_t state_r;

  logic       key_hit;
  logic [4:0] key_idx;

  // evdev key code to button slot
  always_comb begin
    key_hit = 1'b1;
    key_idx = 5'd0;
    unique case (item.code)
      10'h130: key_idx = 5'd0;
      10'h131: key_idx = 5'd1;
      10'h133: key_idx = 5'd2;
      10'h134: key_idx = 5'd3;
      10'h136: key_idx = 5'd4;
      10'h137: key_idx = 5'd5;
      10'h138: key_idx = 5'd6;
      10'h139: key_idx = 5'd7;
      10'h13A: key_idx = 5'd8;
      10'h13B: key_idx = 5'd9;
      10'h13D: key_idx = 5'd10;
      10'h13E: key_idx = 5'd11;
      10'h13C: key_idx = 5'd12;
      10'h220: key_idx = gev_pkg::IdxUp;
      10'h221: key_idx = gev_pkg::IdxDown;
      10'h222: key_idx = gev_pkg::IdxLeft;
      10'h223: key_idx = gev_pkg::IdxRight;
      default: key_hit = 1'b0;
    endcase
  end

  always_comb begin
    logic [gev_pkg::NumButtons-1:0] btn;
    logic sel;
    btn       = state_r.buttons;
    sel       = 1'b0;
    state_nxt = state_r;
    unique case (gev_pkg::kind_t'(item.kind))
      gev_pkg::KIND_BUTTON: begin
        if (key_hit) btn[key_idx] = (item.value != 16'sd0);
        state_nxt.buttons = btn;
        sel = btn[gev_pkg::IdxSelect];
        // combos apply in order: USB, pairing, discoverable toggle
        if (sel && btn[gev_pkg::IdxStart]) state_nxt.usb = ~state_r.usb;
        if (sel && btn[gev_pkg::IdxL1]) begin
          state_nxt.pairing      = 1'b1;
          state_nxt.discoverable = 1'b1;
        end
        if (sel && btn[gev_pkg::IdxR1])
          state_nxt.discoverable = ~state_nxt.discoverable;
      end
      gev_pkg::KIND_AXIS: begin
        if (item.code < 10'(gev_pkg::NumAxes))
          state_nxt.axes[item.code[2:0]] = item.value;
      end
      gev_pkg::KIND_CLEAR: begin
        state_nxt.buttons = '0;
        state_nxt.axes    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.buttons      <= '0;
      state_r.axes         <= '0;
      state_r.usb          <= 1'b0;
      state_r.pairing      <= 1'b0;
      state_r.discoverable <= 1'b1;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/gev_report.sv =====
// Packs the controller state into one HID report.
module gev_report (
  input  gev_pkg::pad_state_t state,
  output gev_pkg::out_item_t  report
);

  logic up, down, left, right;
  logic [3:0] hat;

  assign up    = state.buttons[gev_pkg::IdxUp];
  assign down  = state.buttons[gev_pkg::IdxDown];
  assign left  = state.buttons[gev_pkg::IdxLeft];
  assign right = state.buttons[gev_pkg::IdxRight];

  // up+down together cancel; left beats right
  always_comb begin
    priority if (up && !down)
      hat = left ? gev_pkg::HatUpLeft : (right ? gev_pkg::HatUpRight : gev_pkg::HatUp);
    else if (down && !up)
      hat = left ? gev_pkg::HatDownLeft
                 : (right ? gev_pkg::HatDownRight : gev_pkg::HatDown);
    else if (left)
      hat = gev_pkg::HatLeft;
    else if (right)
      hat = gev_pkg::HatRight;
    else
      hat = gev_pkg::HatNeutral;
  end

  function automatic logic [7:0] stick(input logic [15:0] pos);
    return {~pos[15], pos[14:8]};
  endfunction

  function automatic logic [7:0] trig(input logic [15:0] pos);
    return pos[9:2];
  endfunction

  always_comb begin
    report.button_bits   = state.buttons[gev_pkg::ReportBtns-1:0];
    report.hat           = hat;
    report.left_x        = stick(state.axes[gev_pkg::AxLeftX]);
    report.left_y        = stick(state.axes[gev_pkg::AxLeftY]);
    report.right_x       = stick(state.axes[gev_pkg::AxRightX]);
    report.right_y       = stick(state.axes[gev_pkg::AxRightY]);
    report.left_trigger  = trig(state.axes[gev_pkg::AxLeftTrg]);
    report.right_trigger = trig(state.axes[gev_pkg::AxRightTrg]);
    report.usb_mode      = state.usb;
    report.pairing_mode  = state.pairing;
    report.discoverable  = state.discoverable;
  end

endmodule
